// ===== sv/fsq_pkg.sv =====
package fsq_pkg;

  localparam int VALUE_W   = 16;   // signed fixed-point input component
  localparam int CODE_W    = 24;   // codebook index, wraps modulo 2^24
  localparam int CFG_W     = 5;    // level register width
  localparam int CFG_IDX_W = 4;    // register index width

  localparam logic [CFG_W-1:0] LEVEL_RST_LO = 5'd8;  // dims 0..2
  localparam logic [CFG_W-1:0] LEVEL_RST_HI = 5'd5;  // dims 3 and up
  localparam int               LEVEL_RST_SPLIT = 3;

  localparam logic [63:0] LN2_Q32 = 64'd2977044472;

  // log2(n) in unsigned Q.32, n in 1..1023, by repeated squaring of the mantissa.
  function automatic logic [63:0] fsq_log2_q32(input int n);
    logic [63:0] e;
    logic [63:0] y;
    logic [63:0] frac;
    logic [63:0] nn;
    nn   = 64'(n);
    e    = '0;
    frac = '0;
    while (e < 64'd9 && (nn >> (e + 64'd1)) != 64'd0) begin
      e = e + 64'd1;
    end
    y = (nn << 30) >> e;
    for (int i = 0; i < 32; i++) begin
      y    = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (64'd1 << 31)) begin
        y    = y >> 1;
        frac = frac | 64'd1;
      end
    end
    return (e << 32) | frac;
  endfunction

  // Shift-subtract quotient, elaboration only.
  function automatic logic [63:0] fsq_udiv(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Threshold magnitude in Q.40 for 2k > lv.
  function automatic logic [63:0] fsq_thr_mag(input int lv, input int k);
    logic [63:0] d;
    logic [63:0] p;
    d = fsq_log2_q32(k) - fsq_log2_q32(lv - k);
    p = ((d >> 8) * LN2_Q32) >> 16;
    return fsq_udiv(p * 64'(lv), 64'(2 * (lv - 1)));
  endfunction

  // Threshold T_k for lv levels at frac fraction bits.
  function automatic longint fsq_threshold(input int lv, input int k, input int frac);
    int          sh;
    logic [63:0] m;
    sh = 40 - frac;
    if (2 * k == lv) begin
      return 64'sd0;
    end
    if (2 * k > lv) begin
      m = fsq_thr_mag(lv, k);
      return signed'((m + (64'd1 << sh) - 64'd1) >> sh);
    end
    m = fsq_thr_mag(lv, lv - k);
    return -signed'(m >> sh);
  endfunction

endpackage

// ===== sv/fsq_slicer.sv =====
module fsq_slicer #(
  parameter int MAX_LEVELS = 16,
  parameter int FRAC_BITS  = 12,
  parameter int LW         = 5,
  parameter int CW         = 4
) (
  input  logic signed [fsq_pkg::VALUE_W-1:0] value,
  input  logic [LW-1:0]                      level,
  output logic [CW-1:0]                      comp
);
  import fsq_pkg::*;

  localparam int TW    = FRAC_BITS + 3;
  localparam int CMP_W = (TW > VALUE_W) ? TW : VALUE_W;
  localparam int NCMP  = MAX_LEVELS - 1;

  // Column k of the threshold table: T_k for every level, zero where k >= level.
  function automatic logic [(MAX_LEVELS+1)*TW-1:0] thr_col(input int k);
    logic [(MAX_LEVELS+1)*TW-1:0] col;
    col = '0;
    for (int lv = 0; lv <= MAX_LEVELS; lv++) begin
      if (k < lv) begin
        col[lv*TW +: TW] = TW'(fsq_threshold(lv, k, FRAC_BITS));
      end
    end
    return col;
  endfunction

  logic [NCMP-1:0]          hit;
  logic signed [CMP_W-1:0]  x_ext;

  assign x_ext = CMP_W'(value);

  for (genvar k = 1; k <= NCMP; k++) begin : g_cmp
    localparam logic [(MAX_LEVELS+1)*TW-1:0] COL = thr_col(k);
    logic signed [TW-1:0]    thr;
    logic signed [CMP_W-1:0] thr_ext;
    assign thr     = COL[level*TW +: TW];
    assign thr_ext = CMP_W'(thr);
    assign hit[k-1] = (LW'(k) < level) && (x_ext >= thr_ext);
  end

  // thermometer count of reached thresholds
  always_comb begin
    comp = '0;
    for (int i = 0; i < NCMP; i++) begin
      comp = comp + CW'(hit[i]);
    end
  end

endmodule

// ===== sv/fsq_cell.sv =====
module fsq_cell #(
  parameter int DIMS = 6,
  parameter int IDX  = 0,
  parameter int LW   = 5,
  parameter int CW   = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [LW-1:0]                     level,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fsq_pkg::CODE_W-1:0]        in_code,
  input  logic [fsq_pkg::CODE_W-1:0]        in_weight,
  input  logic [DIMS-1:0][CW-1:0]           in_comp,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fsq_pkg::CODE_W-1:0]        out_code,
  output logic [fsq_pkg::CODE_W-1:0]        out_wt,
  output logic [DIMS-1:0][CW-1:0]           out_comp,
  output logic                              out_last
);
  import fsq_pkg::*;

  logic                       valid_r;
  logic [CODE_W-1:0]          code_r, code_nxt;
  logic [CODE_W-1:0]          weight_r, weight_nxt;
  logic [DIMS-1:0][CW-1:0]    comp_r;
  logic                       last_r;
  logic [CW+CODE_W-1:0]       term;
  logic [LW+CODE_W-1:0]       wprod;
  logic                       take;

  assign in_ready = !valid_r || out_ready;
  assign take     = in_valid && in_ready;

  // code += comp * weight ; weight *= level, both modulo 2^24
  assign term       = in_comp[IDX] * in_weight;
  assign wprod      = in_weight * level;
  assign code_nxt   = in_code + term[CODE_W-1:0];
  assign weight_nxt = wprod[CODE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      code_r   <= code_nxt;
      weight_r <= weight_nxt;
      comp_r   <= in_comp;
      last_r   <= in_last;
    end
  end

  assign out_valid  = valid_r;
  assign out_code   = code_r;
  assign out_wt     = weight_r;
  assign out_comp   = comp_r;
  assign out_last   = last_r;

  a_take_fills : assert property (@(posedge clk) disable iff (!rst_n)
    take |=> valid_r)
    else $error("cell dropped a request");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |=> valid_r && $stable(code_r) && $stable(last_r))
    else $error("cell lost a stalled request");

  a_zero_comp : assert property (@(posedge clk) disable iff (!rst_n)
    take && in_comp[IDX] == '0 |=> code_r == $past(in_code))
    else $error("zero component changed the code");

endmodule

// ===== sv/fsq_code_quantizer.sv =====
// An accepted row is registered in stage 0, then in each radix cell in order.
// Throughput: one row per cycle without output stall; the comparator bank and each radix
//   cell take a new row every cycle, and a stalled output only backs up the stages behind it.
// Reset (rst_n low at a clock edge): all stage valids clear, level registers
//   return to 8, 8, 8, 5, 5, 5 (dims 0..2 get 8, the rest 5).
module fsq_code_quantizer #(
  parameter int DIMS       = 6,
  parameter int MAX_LEVELS = 16,
  parameter int FRAC_BITS  = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: value_0 [15:0], value_1 [31:16], ... value_(DIMS-1) at the top
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [DIMS*fsq_pkg::VALUE_W-1:0]    in_tdata,
  input  logic                                in_tlast,    // last_row
  // out_tdata: code [23:0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fsq_pkg::CODE_W-1:0]          out_tdata,
  output logic                                out_tlast,   // last_code
  input  logic                                cfg_we,
  input  logic [fsq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fsq_pkg::CFG_W-1:0]           cfg_data
);
  import fsq_pkg::*;

  localparam int LW = $clog2(MAX_LEVELS + 1);   // effective level width
  localparam int CW = $clog2(MAX_LEVELS);       // component width, 0..L-1

  // level register -> effective level: below two counts as one, clip at MAX_LEVELS
  function automatic logic [LW-1:0] eff_level(input logic [CFG_W-1:0] r);
    if (r < CFG_W'(2)) begin
      return LW'(1);
    end
    if (int'(r) > MAX_LEVELS) begin
      return LW'(MAX_LEVELS);
    end
    return LW'(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Level registers: the user writes only while the pipe is empty; not enforced
  // ---------------------------------------------------------------------------
  logic [DIMS-1:0][CFG_W-1:0] level_r;
  logic [DIMS-1:0][LW-1:0]    level_eff;

  always_ff @(posedge clk) begin
    for (int d = 0; d < DIMS; d++) begin
      if (!rst_n) begin
        level_r[d] <= (d < LEVEL_RST_SPLIT) ? LEVEL_RST_LO : LEVEL_RST_HI;
      end else if (cfg_we && cfg_index == CFG_IDX_W'(d)) begin
        level_r[d] <= cfg_data;
      end
    end
  end

  for (genvar d = 0; d < DIMS; d++) begin : g_lvl
    assign level_eff[d] = eff_level(level_r[d]);
  end

  // ---------------------------------------------------------------------------
  // Stage 0: threshold compare per dimension, all dims in parallel
  // ---------------------------------------------------------------------------
  logic                       s0_valid_r;
  logic [DIMS-1:0][CW-1:0]    s0_comp_r, s0_comp_nxt;
  logic                       s0_last_r;
  logic                       s0_take;

  logic [DIMS:0]                          c_valid;
  logic [DIMS:0]                          c_ready;
  logic [DIMS:0][CODE_W-1:0]              c_code;
  logic [DIMS:0][CODE_W-1:0]              c_weight;
  logic [DIMS:0][DIMS-1:0][CW-1:0]        c_comp;
  logic [DIMS:0]                          c_last;

  for (genvar d = 0; d < DIMS; d++) begin : g_slice
    fsq_slicer #(
      .MAX_LEVELS (MAX_LEVELS),
      .FRAC_BITS  (FRAC_BITS),
      .LW         (LW),
      .CW         (CW)
    ) u_slicer (
      .value (signed'(in_tdata[d*VALUE_W +: VALUE_W])),
      .level (level_eff[d]),
      .comp  (s0_comp_nxt[d])
    );
  end

  assign in_tready = !s0_valid_r || c_ready[0];
  assign s0_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_tready) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_take) begin
      s0_comp_r <= s0_comp_nxt;
      s0_last_r <= in_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // Mixed-radix chain: cell d adds comp[d] * weight and scales weight by L_d
  // ---------------------------------------------------------------------------
  assign c_valid[0]  = s0_valid_r;
  assign c_code[0]   = '0;
  assign c_weight[0] = CODE_W'(1);
  assign c_comp[0]   = s0_comp_r;
  assign c_last[0]   = s0_last_r;

  for (genvar d = 0; d < DIMS; d++) begin : g_cell
    fsq_cell #(
      .DIMS (DIMS),
      .IDX  (d),
      .LW   (LW),
      .CW   (CW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .level      (level_eff[d]),
      .in_valid   (c_valid[d]),
      .in_ready   (c_ready[d]),
      .in_code    (c_code[d]),
      .in_weight  (c_weight[d]),
      .in_comp    (c_comp[d]),
      .in_last    (c_last[d]),
      .out_valid  (c_valid[d+1]),
      .out_ready  (c_ready[d+1]),
      .out_code   (c_code[d+1]),
      .out_wt     (c_weight[d+1]),
      .out_comp   (c_comp[d+1]),
      .out_last   (c_last[d+1])
    );
  end

  // the last cell's register is the output register
  assign c_ready[DIMS] = out_tready;
  assign out_tvalid    = c_valid[DIMS];
  assign out_tdata     = c_code[DIMS];
  assign out_tlast     = c_last[DIMS];

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  for (genvar d = 0; d < DIMS; d++) begin : g_chk
    a_comp_range : assert property (@(posedge clk) disable iff (!rst_n)
      s0_valid_r |-> LW'(s0_comp_r[d]) < level_eff[d])
      else $error("component beyond level count");
  end

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !s0_valid_r)
    else $error("pipe not empty after reset");

  a_backpressure : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s0_valid_r && !c_ready[0])
    else $error("input stalled with room in stage 0");

endmodule

// ===== verif/fsq_code_quantizer_tb.sv =====
`timescale 1ns / 100ps

// Testbench for fsq_code_quantizer.
// Each row sent is predicted by a local quantizer model, which builds its
// own threshold table at time zero. Results are checked in order against
// that prediction. Bursty input traffic and patterned output stalls keep
// the pipeline busy at different fill levels.
module fsq_code_quantizer_tb;

  import fsq_pkg::*;

  localparam int NUM_DIMS     = 6;
  localparam int MAX_LEVELS   = 16;
  localparam int FRAC_BITS    = 12;
  localparam int Q40_SHIFT    = 40 - FRAC_BITS;  // Q.40 magnitude -> FRAC_BITS
  localparam int PIPE_LATENCY = NUM_DIMS + 1;
  localparam int CYCLE_LIMIT  = 200000;

  // ln(2) in unsigned Q.32
  localparam logic [63:0] LN2_FRAC = 64'd2977044472;

  // Register map: one level register per dim, the rest of the index space unused
  localparam int unsigned REG_LEVEL_DIM0 = 0;
  localparam int unsigned REG_FIRST_FREE = NUM_DIMS;
  localparam int unsigned REG_INDEX_TOP  = (1 << CFG_IDX_W) - 1;

  typedef struct packed {
    logic [NUM_DIMS-1:0][VALUE_W-1:0] value;     // value_0 in the low bits
    logic                             last_row;
  } quant_row_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last_code;
  } quant_result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports (all driven to known values from time zero)
  // ---------------------------------------------------------------------------
  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [NUM_DIMS*VALUE_W-1:0]   in_tdata   = '0;
  logic                          in_tlast   = 1'b0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [CODE_W-1:0]             out_tdata;
  logic                          out_tlast;
  logic                          cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index  = '0;
  logic [CFG_W-1:0]              cfg_data   = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  fsq_code_quantizer #(
    .DIMS       (NUM_DIMS),
    .MAX_LEVELS (MAX_LEVELS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Quantizer model: level registers as the DUT should hold them, plus the
  // Q4.12 decision thresholds T_k for every level count 2..MAX_LEVELS.
  // ---------------------------------------------------------------------------
  logic [NUM_DIMS-1:0][CFG_W-1:0] cur_levels;
  longint                         thr_tab [0:MAX_LEVELS][0:MAX_LEVELS-1];
  quant_result_t                  pending_codes [$];
  int unsigned                    fail_count  = 0;
  int unsigned                    cycle_count = 0;

  // Receiver control: a test posts a long hold here, the receiver counts it out
  int unsigned                    rx_hold_req = 0;

  // log2(n) in unsigned Q.32: integer part from the leading one, fraction
  // by squaring the Q2.30 mantissa 32 times (each square truncated).
  function automatic logic [63:0] log2_fixed(input int n);
    logic [63:0] mant;
    logic [63:0] bits;
    int          ex;
    ex = 0;
    while (ex < 9 && (n >> (ex + 1)) != 0) ex++;
    mant = (64'(n) << 30) >> ex;
    bits = '0;
    repeat (32) begin
      mant = (mant * mant) >> 30;
      bits = bits << 1;
      if (mant >= (64'd1 << 31)) begin
        mant    = mant >> 1;
        bits[0] = 1'b1;
      end
    end
    return (64'(ex) << 32) | bits;
  endfunction

  // T_k = L*ln(k/(L-k)) / (2(L-1)). Upper half rounds its magnitude up, the
  // mirrored lower half rounds toward zero; the middle one is exactly zero.
  function automatic longint level_threshold(input int lv, input int k);
    int          hi;
    logic [63:0] diff;
    logic [63:0] scaled;
    logic [63:0] mag;
    if (2 * k == lv) return 0;
    hi     = (2 * k > lv) ? k : lv - k;
    diff   = log2_fixed(hi) - log2_fixed(lv - hi);
    scaled = ((diff >> 8) * LN2_FRAC) >> 16;           // Q.24 x Q.32 -> Q.40
    mag    = (scaled * 64'(lv)) / 64'(2 * (lv - 1));
    if (2 * k > lv) return longint'((mag + (64'd1 << Q40_SHIFT) - 64'd1) >> Q40_SHIFT);
    return -longint'(mag >> Q40_SHIFT);
  endfunction

  // Register value -> level count actually used (0/1 -> 1, above max saturates)
  function automatic int active_levels(input logic [CFG_W-1:0] r);
    if (r < CFG_W'(2)) return 1;
    if (r > CFG_W'(MAX_LEVELS)) return MAX_LEVELS;
    return int'(r);
  endfunction

  // Component per dim = number of thresholds reached; mixed-radix combine.
  function automatic quant_result_t quantize_row(input quant_row_t row);
    quant_result_t res;
    logic [63:0]   acc;
    logic [63:0]   weight;
    int            lv;
    int            comp;
    acc    = '0;
    weight = 64'd1;
    for (int d = 0; d < NUM_DIMS; d++) begin
      lv   = active_levels(cur_levels[d]);
      comp = 0;
      for (int k = 1; k < lv; k++) begin
        if (longint'($signed(row.value[d])) >= thr_tab[lv][k]) comp++;
      end
      acc    = acc + 64'(comp) * weight;
      weight = weight * 64'(lv);
    end
    res.code      = acc[CODE_W-1:0];
    res.last_code = row.last_row;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic quant_row_t flat_row(input logic [VALUE_W-1:0] v, input logic last);
    quant_row_t row;
    for (int d = 0; d < NUM_DIMS; d++) row.value[d] = v;
    row.last_row = last;
    return row;
  endfunction

  // Every dim sits on its k-th threshold (clipped to its top one), plus offset
  function automatic quant_row_t threshold_row(input int k, input int offset,
                                               input logic last);
    quant_row_t row;
    int         lv;
    for (int d = 0; d < NUM_DIMS; d++) begin
      lv           = active_levels(cur_levels[d]);
      row.value[d] = VALUE_W'(thr_tab[lv][(k < lv) ? k : lv - 1] + offset);
    end
    row.last_row = last;
    return row;
  endfunction

  // Often on or next to a threshold of the dim's current level count,
  // then near-range, full-range and the extreme codes.
  function automatic logic [VALUE_W-1:0] pick_value(input int d);
    int          lv;
    int unsigned sel;
    lv  = active_levels(cur_levels[d]);
    sel = $urandom_range(19, 0);
    if (sel < 8 && lv > 1)
      return VALUE_W'(thr_tab[lv][$urandom_range(lv - 1, 1)]
                      + longint'($urandom_range(2, 0)) - 1);
    if (sel < 13) return VALUE_W'(int'($urandom_range(24576, 0)) - 12288);
    if (sel < 17) return VALUE_W'($urandom);
    case ($urandom_range(3, 0))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic quant_row_t random_row();
    quant_row_t row;
    for (int d = 0; d < NUM_DIMS; d++) row.value[d] = pick_value(d);
    row.last_row = ($urandom_range(7, 0) == 0);  // chunk end now and then
    return row;
  endfunction

  // Level register value: mostly legal, with the edges and the odd values
  function automatic logic [CFG_W-1:0] pick_level();
    case ($urandom_range(9, 0))
      0:       return CFG_W'(2);
      1:       return CFG_W'(MAX_LEVELS);
      2:       return CFG_W'($urandom_range(1, 0));            // collapses to one level
      3:       return CFG_W'($urandom_range(31, MAX_LEVELS + 1)); // saturates
      default: return CFG_W'($urandom_range(MAX_LEVELS, 2));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. valid is left high after a request is taken; the gap task or
  // the drain lowers it, so valid never gets two updates in one step.
  // ---------------------------------------------------------------------------
  task automatic send_row(input quant_row_t row);
    in_tvalid <= 1'b1;
    in_tdata  <= row.value;
    in_tlast  <= row.last_row;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_codes = {pending_codes, quantize_row(row)};
  endtask

  task automatic hold_sender(input int unsigned cycles);
    if (cycles != 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stop offering, wait for every predicted code, then let the pipe go quiet
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Only called with the block idle. One write to an unused index goes first;
  // the block must ignore it.
  task automatic program_levels(input logic [NUM_DIMS-1:0][CFG_W-1:0] lv);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_W'($urandom_range(REG_INDEX_TOP, REG_FIRST_FREE));
    cfg_data  <= CFG_W'($urandom);
    @(posedge clk);
    for (int d = 0; d < NUM_DIMS; d++) begin
      cfg_index <= CFG_IDX_W'(REG_LEVEL_DIM0 + d);
      cfg_data  <= lv[d];
      @(posedge clk);
      cur_levels[d] = lv[d];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset levels (8,8,8,5,5,5): range ends, zero, -1, and exact threshold ties
  // (a tie must round up) plus one LSB below a few of them.
  task automatic test_reset_levels();
    send_row(flat_row(16'h8000, 1'b0));
    send_row(flat_row(16'h7FFF, 1'b1));
    send_row(flat_row(16'h0000, 1'b0));
    send_row(flat_row(16'hFFFF, 1'b1));
    for (int k = 1; k < 8; k++) send_row(threshold_row(k, 0, k[0]));
    for (int k = 1; k < 8; k += 3) send_row(threshold_row(k, -1, 1'b0));
    drain_results();
  endtask

  // All dims at max levels (largest codes), then a mix of one/zero levels,
  // saturating values and the two-level case.
  task automatic test_level_extremes();
    quant_row_t row;
    program_levels({NUM_DIMS{CFG_W'(MAX_LEVELS)}});
    send_row(flat_row(16'h7FFF, 1'b1));
    send_row(flat_row(16'h8000, 1'b0));
    drain_results();
    // dim0..5 = 0, 1, 17, 31, 2, 16
    program_levels({CFG_W'(16), CFG_W'(2), CFG_W'(31), CFG_W'(17), CFG_W'(1), CFG_W'(0)});
    send_row(flat_row(16'h7FFF, 1'b0));
    send_row(flat_row(16'h0000, 1'b1));
    for (int d = 0; d < NUM_DIMS; d++) row.value[d] = d[0] ? 16'h8000 : 16'h7FFF;
    row.last_row = 1'b0;
    send_row(row);
    drain_results();
  endtask

  // Receiver holds off for a long stretch while rows keep coming back to back:
  // the pipe fills and in_tready has to drop.
  task automatic test_output_backpressure();
    rx_hold_req = 250;
    repeat (64) send_row(random_row());
    drain_results();
  endtask

  // Random rows over several level settings. Bursts of random length with
  // random gaps; every third phase runs with no gaps at all.
  task automatic test_random_rows(input int unsigned phases, input int unsigned rows);
    logic [NUM_DIMS-1:0][CFG_W-1:0] lv;
    int unsigned                    burst_left;
    int unsigned                    gap_max;
    for (int unsigned p = 0; p < phases; p++) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
        if (p == 0)      lv[d] = CFG_W'(2);
        else if (p == 1) lv[d] = CFG_W'(MAX_LEVELS);
        else             lv[d] = pick_level();
      end
      program_levels(lv);
      gap_max    = (p % 3 == 2) ? 0 : ((p % 3 == 0) ? 3 : 12);
      burst_left = 0;
      for (int unsigned i = 0; i < rows; i++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(32, 1);
          hold_sender($urandom_range(gap_max, 0));
        end
        send_row(random_row());
        burst_left--;
      end
      drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: segments of random length, each with its own stall rate (zero
  // for some, so there are clean stretches). A posted hold overrides it.
  // ---------------------------------------------------------------------------
  int unsigned rx_hold_left = 0;
  int unsigned rx_seg_left  = 0;
  int unsigned rx_stall_pct = 0;

  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_seg_left == 0) begin
        rx_seg_left = $urandom_range(200, 10);
        case ($urandom_range(3, 0))
          0:       rx_stall_pct = 0;
          1:       rx_stall_pct = 20;
          2:       rx_stall_pct = 50;
          default: rx_stall_pct = 85;
        endcase
      end
      rx_seg_left--;
      out_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every accepted code against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    quant_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_codes.size() == 0) begin
        $error("unexpected result: code %0d last_code %0b", out_tdata, out_tlast);
        fail_count++;
      end else begin
        want = pending_codes.pop_front();
        if (out_tdata !== want.code) begin
          $error("code: expected %0d, actual %0d", want.code, out_tdata);
          fail_count++;
        end
        if (out_tlast !== want.last_code) begin
          $error("last_code: expected %0b, actual %0b", want.last_code, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL fsq_code_quantizer");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int lv = 2; lv <= MAX_LEVELS; lv++) begin
      for (int k = 1; k < lv; k++) thr_tab[lv][k] = level_threshold(lv, k);
    end
    for (int d = 0; d < NUM_DIMS; d++)
      cur_levels[d] = (d < LEVEL_RST_SPLIT) ? LEVEL_RST_LO : LEVEL_RST_HI;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_levels();
    test_level_extremes();
    test_output_backpressure();
    test_random_rows(8, 220);

    if (fail_count == 0 && pending_codes.size() == 0) begin
      $display("PASS fsq_code_quantizer");
    end else begin
      $display("FAIL fsq_code_quantizer");
    end
    $finish;
  end

endmodule
